### design/p8f32_pkg.sv
// p8f32_pkg: shared types and constants for the posit8/float32 converter.
// No dependencies.
`default_nettype none
package p8f32_pkg;
  localparam logic CmdF2p = 1'b0;
  localparam logic CmdP2f = 1'b1;
  localparam logic [7:0] PositNar = 8'h80;
  localparam logic [7:0] PositMaxpos = 8'h7F;
  localparam logic [7:0] PositMinpos = 8'h01;
  localparam logic [31:0] FloatQnan = 32'h7FC00000;

  typedef struct packed {
    logic        cmd;
    logic [31:0] operand;
  } req_t;

  typedef struct packed {
    logic [31:0] result;
    logic        is_nar;
  } rsp_t;

  // stage 1 -> stage 2
  typedef struct packed {
    logic        cmd;
    logic        neg;
    logic        special;
    logic [31:0] special_val;
    logic        special_nar;
    // float to posit
    logic        f2p_pos;
    logic [2:0]  f2p_shamt;
    logic [22:0] man;
    // posit to float
    logic [6:0]  body;
  } s1_t;

  // stage 2 -> stage 3
  typedef struct packed {
    logic        cmd;
    logic        neg;
    logic        special;
    logic [31:0] special_val;
    logic        special_nar;
    logic [7:0]  f2p_body;
    logic [6:0]  body;
    logic [2:0]  run;
    logic        lead;
  } s2_t;
endpackage
`default_nettype wire

### design/p8f32_if.sv
// p8f32_if: valid/ready channel carrying one transaction payload.
// Depends on nothing; payload type is a parameter.
`default_nettype none
interface p8f32_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/p8f32_decode.sv
// p8f32_decode: stage 1 logic, field decode and special cases.
// Depends on p8f32_pkg.
`default_nettype none
module p8f32_decode (
  input  var p8f32_pkg::req_t req_i,
  output var p8f32_pkg::s1_t  s1_o
);
  import p8f32_pkg::*;
  logic [7:0] ef;
  logic [7:0] p;
  logic [7:0] pa;
  always_comb begin
    ef = req_i.operand[30:23];
    p  = req_i.operand[7:0];
    pa = p[7] ? 8'(0 - p) : p;
    s1_o = '0;
    s1_o.cmd = req_i.cmd;
    s1_o.man = req_i.operand[22:0];
    s1_o.body = pa[6:0];
    if (req_i.cmd == CmdF2p) begin
      s1_o.neg = req_i.operand[31];
      if (ef == 8'hFF) begin
        s1_o.special = 1'b1;
        s1_o.special_val = {24'd0, PositNar};
        s1_o.special_nar = 1'b1;
      end else if (ef == 8'd0 && req_i.operand[22:0] == '0) begin
        s1_o.special = 1'b1;
      end else if (ef == 8'd0 || ef < 8'd121) begin
        s1_o.special = 1'b1;
        s1_o.special_val = {24'd0, req_i.operand[31] ? 8'hFF : PositMinpos};
      end else if (ef >= 8'd133) begin
        s1_o.special = 1'b1;
        s1_o.special_val = {24'd0, req_i.operand[31] ? 8'h81 : PositMaxpos};
      end else if (ef >= 8'd127) begin
        s1_o.f2p_pos = 1'b1;
        s1_o.f2p_shamt = 3'(ef - 8'd127);
      end else begin
        s1_o.f2p_shamt = 3'(8'd127 - ef);
      end
    end else begin
      s1_o.neg = p[7];
      if (p == 8'd0) begin
        s1_o.special = 1'b1;
      end else if (p == PositNar) begin
        s1_o.special = 1'b1;
        s1_o.special_val = FloatQnan;
        s1_o.special_nar = 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

### design/p8f32_regime.sv
// p8f32_regime: stage 2 logic, regime build (float to posit) and
// regime run count (posit to float). Depends on p8f32_pkg.
`default_nettype none
module p8f32_regime (
  input  var p8f32_pkg::s1_t s1_i,
  output var p8f32_pkg::s2_t s2_o
);
  import p8f32_pkg::*;
  logic [7:0] ones;
  logic [7:0] frac;
  logic [2:0] run;
  logic       stop;
  always_comb begin
    s2_o = '0;
    s2_o.cmd = s1_i.cmd;
    s2_o.neg = s1_i.neg;
    s2_o.special = s1_i.special;
    s2_o.special_val = s1_i.special_val;
    s2_o.special_nar = s1_i.special_nar;
    s2_o.body = s1_i.body;
    if (s1_i.f2p_pos) begin
      ones = 8'((8'h2 << s1_i.f2p_shamt) - 8'd1);
      ones = 8'(ones << (3'd6 - s1_i.f2p_shamt));
      frac = 8'(s1_i.man >> (5'd18 + 5'(s1_i.f2p_shamt)));
    end else begin
      ones = 8'(8'd1 << (3'd6 - s1_i.f2p_shamt));
      frac = 8'(s1_i.man >> (5'd17 + 5'(s1_i.f2p_shamt)));
    end
    s2_o.f2p_body = ones | frac;
    run = 3'd0;
    stop = 1'b0;
    for (int i = 6; i >= 0; i--) begin
      if (s1_i.body[i] != s1_i.body[6]) stop = 1'b1;
      if (!stop) run = 3'(run + 3'd1);
    end
    s2_o.run = run;
    s2_o.lead = s1_i.body[6];
  end
endmodule
`default_nettype wire

### design/p8f32_pack.sv
// p8f32_pack: stage 3 logic, sign apply, special-case select, and posit and float assembly.
// Depends on p8f32_pkg.
`default_nettype none
module p8f32_pack (
  input  var p8f32_pkg::s2_t  s2_i,
  output var p8f32_pkg::rsp_t rsp_o
);
  import p8f32_pkg::*;
  logic [7:0]  pb;
  logic [2:0]  rem;
  logic [5:0]  frac;
  logic [7:0]  ef;
  always_comb begin
    rsp_o = '0;
    pb = s2_i.neg ? 8'(0 - s2_i.f2p_body) : s2_i.f2p_body;
    rem = (s2_i.run >= 3'd6) ? 3'd0 : 3'(3'd6 - s2_i.run);
    frac = 6'(s2_i.body & 7'((7'd1 << rem) - 7'd1));
    ef = s2_i.lead ? 8'(8'd126 + 8'(s2_i.run)) : 8'(8'd127 - 8'(s2_i.run));
    if (s2_i.special) begin
      rsp_o.result = s2_i.special_val;
      rsp_o.is_nar = s2_i.special_nar;
    end else if (s2_i.cmd == CmdF2p) begin
      rsp_o.result = {24'd0, pb};
    end else begin
      rsp_o.result = {s2_i.neg, ef, 23'({frac, 23'd0} >> rem)};
    end
  end
endmodule
`default_nettype wire

### design/posit8_float32_converter.sv
// posit8_float32_converter: top level, three-stage pipeline.
// Depends on p8f32_pkg, p8f32_if, p8f32_decode, p8f32_regime, p8f32_pack.
//
// Converts float32 to posit8 (es=0) when cmd is 0 and posit8 to float32
// when cmd is 1. Three register stages (decode, regime, pack) hold each
// transaction in turn, and one transaction is accepted every cycle while
// the output is not stalled. The pipeline advances whenever the output
// stage is empty or being taken, so stalls back up without loss.
`default_nettype none
module posit8_float32_converter (
  input  wire clk_i,
  input  wire rst_ni,
  p8f32_if.sink   req_i,
  p8f32_if.source rsp_o
);
  import p8f32_pkg::*;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  rsp_t r_d, r_q;
  logic v1_q, v2_q, v3_q;
  logic adv;

  assign adv = !v3_q || rsp_o.ready;
  assign req_i.ready = adv;
  assign rsp_o.valid = v3_q;
  assign rsp_o.data = r_q;

  p8f32_decode u_dec (.req_i(req_i.data), .s1_o(s1_d));
  p8f32_regime u_reg (.s1_i(s1_q), .s2_o(s2_d));
  p8f32_pack   u_pck (.s2_i(s2_q), .rsp_o(r_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= req_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      r_q  <= r_d;
    end
  end
endmodule
`default_nettype wire
